>>> design/pipas_pkg.sv
// Shared constants, arctangent table and stage types for the angle-sum polygon test.
`default_nettype none

package pipas_pkg;

   localparam int CORDIC_W     = 62;
   localparam int CORDIC_STEPS = 31;
   localparam int DIR_W        = 32;
   localparam int SCALE_TOP    = 58;
   localparam int TOTAL_W      = 24;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;
   localparam logic [TOTAL_W-1:0] THRESHOLD_RESET = 24'd64881;
   localparam logic [DIR_W-1:0]   HALF_TURN       = 32'h8000_0000;

   // Arctangent of 2^-i as an unsigned fraction of a full turn.
   localparam logic [DIR_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001
   };

   typedef struct packed {
      logic vld;
      logic zero;
      logic first;
      logic last;
   } tag_type;

   typedef struct packed {
      tag_type                tag;
      logic [CORDIC_W-1:0]    x;
      logic [CORDIC_W-1:0]    y;
      logic [DIR_W-1:0]       z;
   } cordic_type;

endpackage

`default_nettype wire

>>> design/pipas_if.sv
// Handshake interfaces for the vertex, result and threshold channels.
`default_nettype none

interface pipas_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic                          last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output point_x,
                   output point_y, output last_vertex, input ready);
   modport sink (input valid, input vertex_x, input vertex_y, input point_x,
                 input point_y, input last_vertex, output ready);
endinterface

interface pipas_rsp_if ();
   import pipas_pkg::*;
   logic               valid;
   logic               ready;
   logic               inside_res;
   logic [TOTAL_W-1:0] angle_total;

   modport source (output valid, output inside_res, output angle_total, input ready);
   modport sink (input valid, input inside_res, input angle_total, output ready);
endinterface

interface pipas_csr_if ();
   import pipas_pkg::*;
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] inside_threshold;

   modport source (output valid, output inside_threshold, input ready);
   modport sink (input valid, input inside_threshold, output ready);
endinterface

`default_nettype wire

>>> design/pipas_cell.sv
// One vectoring CORDIC cell that rotates the vector by a fixed step and passes it on.
`default_nettype none

module pipas_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pipas_pkg::cordic_type  cell_in,
   output pipas_pkg::cordic_type  cell_out
);
   import pipas_pkg::*;

   cordic_type                 stage_ff;
   cordic_type                 stage_in;
   logic signed [CORDIC_W-1:0] x_cur;
   logic signed [CORDIC_W-1:0] y_cur;
   logic signed [CORDIC_W-1:0] x_sh;
   logic signed [CORDIC_W-1:0] y_sh;

   always_comb begin
      x_cur    = $signed(cell_in.x);
      y_cur    = $signed(cell_in.y);
      x_sh     = x_cur >>> STEP;
      y_sh     = y_cur >>> STEP;
      stage_in = cell_in;
      if (y_cur > 0) begin
         stage_in.x = x_cur + y_sh;
         stage_in.y = y_cur - x_sh;
         stage_in.z = cell_in.z + ATAN_TURN[STEP];
      end else begin
         stage_in.x = x_cur - y_sh;
         stage_in.y = y_cur + x_sh;
         stage_in.z = cell_in.z - ATAN_TURN[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.tag.vld <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign cell_out = stage_ff;

endmodule

`default_nettype wire

>>> design/pipas_accum.sv
// Turns vector directions into folded pair angles and keeps the saturating angle sum.
`default_nettype none

module pipas_accum #(
   parameter int ANGLE_BITS = 16,
   parameter int SUM_WIDTH  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pipas_pkg::cordic_type  dir_in,
   input  logic                   res_take,
   output logic                   item_done,
   output logic                   res_vld,
   output logic [SUM_WIDTH-1:0]   res_sum
);
   import pipas_pkg::*;

   localparam int ACC_W = ((SUM_WIDTH > ANGLE_BITS) ? SUM_WIDTH : ANGLE_BITS) + 2;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

   logic [DIR_W-1:0]      prior_dir_ff;
   logic                  prior_zero_ff;
   logic [DIR_W-1:0]      first_dir_ff;
   logic                  first_zero_ff;
   logic                  a1_vld_ff;
   logic                  a1_first_ff;
   logic                  a1_last_ff;
   logic [DIR_W-1:0]      fold_a_ff;
   logic [DIR_W-1:0]      fold_b_ff;
   logic [DIR_W-1:0]      fold_a_in;
   logic [DIR_W-1:0]      fold_b_in;
   logic                  a2_vld_ff;
   logic                  a2_first_ff;
   logic                  a2_last_ff;
   logic [ANGLE_BITS-1:0] ang_a_ff;
   logic [ANGLE_BITS-1:0] ang_b_ff;
   logic [SUM_WIDTH-1:0]  sum_ff;
   logic [SUM_WIDTH-1:0]  sum_in;
   logic [SUM_WIDTH-1:0]  base;
   logic [ACC_W-1:0]      acc;
   logic                  res_vld_ff;
   logic [SUM_WIDTH-1:0]  res_sum_ff;
   logic [DIR_W-1:0]      close_dir;
   logic                  close_zero;

   // The smaller of the two ways around the circle between two directions.
   function automatic logic [DIR_W-1:0] fold_turn(input logic [DIR_W-1:0] from_dir,
                                                  input logic [DIR_W-1:0] to_dir);
      logic [DIR_W-1:0] fwd;
      logic [DIR_W-1:0] bwd;
      fwd = to_dir - from_dir;
      bwd = from_dir - to_dir;
      return (fwd < bwd) ? fwd : bwd;
   endfunction

   // Rounds half up from 32 bits of a turn to ANGLE_BITS bits of a turn.
   function automatic logic [ANGLE_BITS-1:0] round_angle(input logic [DIR_W-1:0] turn);
      logic [DIR_W:0] biased;
      biased = {1'b0, turn} + ((DIR_W+1)'(1) << (DIR_W - 1 - ANGLE_BITS));
      return biased[DIR_W-ANGLE_BITS +: ANGLE_BITS];
   endfunction

   always_comb begin
      close_dir  = dir_in.tag.first ? dir_in.z : first_dir_ff;
      close_zero = dir_in.tag.first ? dir_in.tag.zero : first_zero_ff;
      if (dir_in.tag.first || prior_zero_ff || dir_in.tag.zero) begin
         fold_a_in = '0;
      end else begin
         fold_a_in = fold_turn(prior_dir_ff, dir_in.z);
      end
      if (!dir_in.tag.last || dir_in.tag.zero || close_zero) begin
         fold_b_in = '0;
      end else begin
         fold_b_in = fold_turn(dir_in.z, close_dir);
      end
   end

   always_comb begin
      base   = a2_first_ff ? '0 : sum_ff;
      acc    = ACC_W'(base) + ACC_W'(ang_a_ff) + ACC_W'(ang_b_ff);
      sum_in = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_vld_ff  <= 1'b0;
         a2_vld_ff  <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         a1_vld_ff <= dir_in.tag.vld;
         a2_vld_ff <= a1_vld_ff;
         if (a2_vld_ff && a2_last_ff) begin
            res_vld_ff <= 1'b1;
         end else if (res_take) begin
            res_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      a1_first_ff <= dir_in.tag.first;
      a1_last_ff  <= dir_in.tag.last;
      fold_a_ff   <= fold_a_in;
      fold_b_ff   <= fold_b_in;
      a2_first_ff <= a1_first_ff;
      a2_last_ff  <= a1_last_ff;
      ang_a_ff    <= round_angle(fold_a_ff);
      ang_b_ff    <= round_angle(fold_b_ff);
      if (dir_in.tag.vld) begin
         prior_dir_ff  <= dir_in.z;
         prior_zero_ff <= dir_in.tag.zero;
         if (dir_in.tag.first) begin
            first_dir_ff  <= dir_in.z;
            first_zero_ff <= dir_in.tag.zero;
         end
      end
      if (a2_vld_ff) begin
         sum_ff <= sum_in;
         if (a2_last_ff) begin
            res_sum_ff <= sum_in;
         end
      end
   end

   assign item_done = a2_vld_ff && !a2_last_ff;
   assign res_vld   = res_vld_ff;
   assign res_sum   = res_sum_ff;

endmodule

`default_nettype wire

>>> design/point_in_polygon_angle_sum.sv
// Top level of the angle-sum point-in-polygon test.
//
// Polygon vertices arrive one word at a time; the query point is taken with the first vertex,
// and a result word (inside flag and saturated angle total) leaves only after the vertex that
// carries last_vertex. Each vertex is worked on alone: its vector from the query point passes
// an entry register, a row of 31 CORDIC cells and three accumulator stages, and a new vertex is
// accepted only once the previous one has reached the last accumulator stage, or, if it closed
// the polygon, once its result has been taken from the accumulator. A closing vertex's result
// waits in the accumulator while the previous result has not been taken, and the next vertex
// waits with it. The threshold register is written through its own channel, ready outside reset, and
// should be changed only while no vertex is in flight.
`default_nettype none

module point_in_polygon_angle_sum #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_BITS  = 16,
   parameter int SUM_WIDTH   = 24
) (
   input  logic         clock,
   input  logic         reset,
   pipas_req_if.sink    req_chan,
   pipas_rsp_if.source  rsp_chan,
   pipas_csr_if.sink    csr_chan
);
   import pipas_pkg::*;

   localparam int SHIFT = SCALE_TOP - COORD_WIDTH;
   localparam int CMP_W = (SUM_WIDTH > TOTAL_W) ? SUM_WIDTH : TOTAL_W;

   logic                          busy_ff;
   logic                          in_polygon_ff;
   logic [TOTAL_W-1:0]            threshold_ff;
   logic signed [COORD_WIDTH-1:0] query_x_ff;
   logic signed [COORD_WIDTH-1:0] query_y_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_inside_ff;
   logic [TOTAL_W-1:0]            rsp_total_ff;
   cordic_type                    entry_ff;
   cordic_type                    entry_in;
   cordic_type                    chain [CORDIC_STEPS+1];

   logic                          accept;
   logic signed [COORD_WIDTH-1:0] qx_sel;
   logic signed [COORD_WIDTH-1:0] qy_sel;
   logic signed [COORD_WIDTH:0]   dx_pos;
   logic signed [COORD_WIDTH:0]   dx_neg;
   logic signed [COORD_WIDTH:0]   dy_pos;
   logic signed [COORD_WIDTH:0]   dy_neg;
   logic signed [COORD_WIDTH:0]   ex;
   logic signed [COORD_WIDTH:0]   ey;
   logic                          flip;

   logic                          item_done;
   logic                          res_vld;
   logic [SUM_WIDTH-1:0]          res_sum;
   logic                          res_take;

   assign accept   = req_chan.valid && req_chan.ready;
   assign res_take = res_vld && (!rsp_valid_ff || rsp_chan.ready);

   // Vectors that point left are turned a half turn so the cells see x >= 0.
   always_comb begin
      qx_sel = in_polygon_ff ? query_x_ff : req_chan.point_x;
      qy_sel = in_polygon_ff ? query_y_ff : req_chan.point_y;
      dx_pos = {req_chan.vertex_x[COORD_WIDTH-1], req_chan.vertex_x}
               - {qx_sel[COORD_WIDTH-1], qx_sel};
      dx_neg = {qx_sel[COORD_WIDTH-1], qx_sel}
               - {req_chan.vertex_x[COORD_WIDTH-1], req_chan.vertex_x};
      dy_pos = {req_chan.vertex_y[COORD_WIDTH-1], req_chan.vertex_y}
               - {qy_sel[COORD_WIDTH-1], qy_sel};
      dy_neg = {qy_sel[COORD_WIDTH-1], qy_sel}
               - {req_chan.vertex_y[COORD_WIDTH-1], req_chan.vertex_y};
      flip   = req_chan.vertex_x < qx_sel;
      ex     = flip ? dx_neg : dx_pos;
      ey     = flip ? dy_neg : dy_pos;

      entry_in.tag.vld   = accept;
      entry_in.tag.zero  = (req_chan.vertex_x == qx_sel) && (req_chan.vertex_y == qy_sel);
      entry_in.tag.first = !in_polygon_ff;
      entry_in.tag.last  = req_chan.last_vertex;
      entry_in.x = {{(CORDIC_W-COORD_WIDTH-1){ex[COORD_WIDTH]}}, ex} << SHIFT;
      entry_in.y = {{(CORDIC_W-COORD_WIDTH-1){ey[COORD_WIDTH]}}, ey} << SHIFT;
      entry_in.z = flip ? HALF_TURN : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         in_polygon_ff    <= 1'b0;
         threshold_ff     <= THRESHOLD_RESET;
         rsp_valid_ff     <= 1'b0;
         entry_ff.tag.vld <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         if (accept) begin
            busy_ff       <= 1'b1;
            in_polygon_ff <= !req_chan.last_vertex;
         end else if (item_done || res_take) begin
            busy_ff <= 1'b0;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            threshold_ff <= csr_chan.inside_threshold;
         end
         if (res_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !in_polygon_ff) begin
         query_x_ff <= req_chan.point_x;
         query_y_ff <= req_chan.point_y;
      end
      if (res_take) begin
         rsp_inside_ff <= CMP_W'(res_sum) >= CMP_W'(threshold_ff);
         rsp_total_ff  <= (CMP_W'(res_sum) > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                : TOTAL_W'(res_sum);
      end
   end

   assign chain[0] = entry_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      pipas_cell #(
         .STEP (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   pipas_accum #(
      .ANGLE_BITS (ANGLE_BITS),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .dir_in    (chain[CORDIC_STEPS]),
      .res_take  (res_take),
      .item_done (item_done),
      .res_vld   (res_vld),
      .res_sum   (res_sum)
   );

   assign req_chan.ready       = !busy_ff && !reset;
   assign csr_chan.ready       = !reset;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.inside_res  = rsp_inside_ff;
   assign rsp_chan.angle_total = rsp_total_ff;

endmodule

`default_nettype wire

>>> design/pipas_check.sv
// Port-level checks of the angle-sum polygon test, bound to its top level.
`default_nettype none

module pipas_check (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_inside,
   input logic [pipas_pkg::TOTAL_W-1:0]   rsp_total
);
   import pipas_pkg::*;

   // A result word that is not taken keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total) && $stable(rsp_inside))
      else $error("result word changed while stalled");

   // Only one vertex is in flight, so the channel closes right after a word is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second vertex accepted while one is in flight");

   // A vertex holds the block for the whole length of the cell row.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##33 !req_ready)
      else $error("vertex left the cell row too early");

   // A new result can only come from a vertex that was in flight.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared with no vertex in flight");

endmodule

bind point_in_polygon_angle_sum pipas_check u_check (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_inside (rsp_chan.inside_res),
   .rsp_total  (rsp_chan.angle_total)
);

`default_nettype wire
